FILE: hdl/vbfe_pkg.sv
package vbfe_pkg;

    // grid limits
    localparam int MAX_X = 4096;
    localparam int MAX_Y = 64;
    localparam int MAX_Z = 64;

    // position counter widths (x also counts the drain plane)
    localparam int X_W  = $clog2(MAX_X + 1);
    localparam int Y_W  = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
    localparam int Z_W  = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
    localparam int NY_W = $clog2(MAX_Y + 2) + 1;
    localparam int NZ_W = $clog2(MAX_Z + 1) + 1;

    // occupancy row store: one row of z bits per (plane parity, y)
    localparam int ROW_W  = MAX_Z;
    localparam int ROWS   = 2 * MAX_Y;
    localparam int ROW_AW = Y_W + 1;

    // fixed field widths
    localparam int VAL_W      = 16;
    localparam int POS_X_W    = 12;
    localparam int POS_Y_W    = 6;
    localparam int POS_Z_W    = 6;
    localparam int SIDE_W     = 3;
    localparam int VERT_W     = 29;
    localparam int NUM_SIDES  = 6;
    localparam int GRID_X_W   = 13;
    localparam int GRID_Y_W   = 7;
    localparam int GRID_Z_W   = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // voxel record queue between classifier and face emitter
    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_Z = 2'd2;

    // item kinds
    localparam logic KIND_VOXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    typedef enum logic [SIDE_W-1:0] {
        SIDE_POS_X = 3'd0,
        SIDE_NEG_X = 3'd1,
        SIDE_POS_Z = 3'd2,
        SIDE_NEG_Z = 3'd3,
        SIDE_POS_Y = 3'd4,
        SIDE_NEG_Y = 3'd5
    } t_side;

    typedef struct packed {
        logic                    kind;
        logic signed [VAL_W-1:0] voxel_value;
    } t_in_item;

    typedef struct packed {
        logic [POS_X_W-1:0] pos_x;
        logic [POS_Y_W-1:0] pos_y;
        logic [POS_Z_W-1:0] pos_z;
        t_side              side;
        logic [VERT_W-1:0]  first_vertex;
        logic               last_face;
    } t_out_item;

    typedef struct packed {
        logic                 fresh;
        logic [NUM_SIDES-1:0] mask;
        logic [POS_X_W-1:0]   pos_x;
        logic [POS_Y_W-1:0]   pos_y;
        logic [POS_Z_W-1:0]   pos_z;
    } t_voxel_rec;

    typedef struct packed {
        logic                full;
        logic                empty;
        logic [QUEUE_CW-1:0] level;
    } t_queue_stat;

endpackage

FILE: hdl/vbfe_ram.sv
module vbfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, two registered read ports that hold their data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

FILE: hdl/vbfe_front.sv
module vbfe_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [vbfe_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [vbfe_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_accept,
    input  vbfe_pkg::t_in_item                  i_item,
    output logic                                o_rec_push,
    output vbfe_pkg::t_voxel_rec                o_rec
);

    localparam int XW   = vbfe_pkg::X_W;
    localparam int YW   = vbfe_pkg::Y_W;
    localparam int ZW   = vbfe_pkg::Z_W;
    localparam int NYW  = vbfe_pkg::NY_W;
    localparam int NZW  = vbfe_pkg::NZ_W;
    localparam int RW   = vbfe_pkg::ROW_W;
    localparam int RAW  = vbfe_pkg::ROW_AW;
    localparam int GXW  = vbfe_pkg::GRID_X_W;
    localparam int GYW  = vbfe_pkg::GRID_Y_W;
    localparam int GZW  = vbfe_pkg::GRID_Z_W;
    localparam int PXW  = vbfe_pkg::POS_X_W;
    localparam int PYW  = vbfe_pkg::POS_Y_W;
    localparam int PZW  = vbfe_pkg::POS_Z_W;
    localparam int MAXX = vbfe_pkg::MAX_X;
    localparam int MAXY = vbfe_pkg::MAX_Y;
    localparam int MAXZ = vbfe_pkg::MAX_Z;

    logic [GXW-1:0] r_gx;
    logic [GYW-1:0] r_gy;
    logic [GZW-1:0] r_gz;
    logic [XW-1:0]  r_x;
    logic [YW-1:0]  r_y;
    logic [ZW-1:0]  r_z;
    logic           r_fresh;
    logic           r_ld;
    logic           r_ld_nc;
    logic           r_a_byp;

    // rows of the plane behind: y-1, y, y+1; row y two planes behind;
    // row 0 of the current plane kept for the next plane; row being built
    logic [RW-1:0] r_m, r_c, r_p, r_o, r_nc, r_w, r_wdone;

    logic [XW-1:0]  nx;
    logic [NYW-1:0] ny;
    logic [NZW-1:0] nz;
    logic           cur;
    logic           z_last, y_last, plane_end, enter_last, wrap;
    logic [XW-1:0]  n_x;
    logic [YW-1:0]  n_y;
    logic [ZW-1:0]  n_z;
    logic [RAW-1:0] w_addr, a_addr, b_addr;
    logic [RW-1:0]  w_final, ram_a, ram_b, a_data;
    logic [RW-1:0]  eff_p, eff_o, eff_nc;
    logic [vbfe_pkg::NUM_SIDES-1:0] mask;
    logic           row_we;

    // sizes in use, saturated to 1..max
    always_comb begin
        nx = (r_gx == '0) ? XW'(1) : ((int'(r_gx) > MAXX) ? XW'(MAXX) : XW'(r_gx));
        ny = (r_gy == '0) ? NYW'(1) : ((int'(r_gy) > MAXY) ? NYW'(MAXY) : NYW'(r_gy));
        nz = (r_gz == '0) ? NZW'(1) : ((int'(r_gz) > MAXZ) ? NZW'(MAXZ) : NZW'(r_gz));
    end

    // occupancy of the incoming item
    assign cur = (i_item.kind == vbfe_pkg::KIND_VOXEL) && (r_x < nx)
                 && (i_item.voxel_value > 16'sd0);

    // raster position bookkeeping
    always_comb begin
        z_last     = (NZW'(r_z) + NZW'(1)) >= nz;
        y_last     = (NYW'(r_y) + NYW'(1)) >= ny;
        plane_end  = z_last && y_last;
        enter_last = z_last && !y_last && ((NYW'(r_y) + NYW'(2)) == ny);
        wrap       = plane_end && (r_x == nx);
        n_z        = z_last ? '0 : r_z + ZW'(1);
        n_y        = z_last ? (y_last ? '0 : r_y + YW'(1)) : r_y;
        if (wrap) begin
            n_x = '0;
        end else if (plane_end) begin
            n_x = r_x + XW'(1);
        end else begin
            n_x = r_x;
        end
    end

    // row fetch addresses for the next row
    always_comb begin
        w_addr = {r_x[0], r_y};
        if (plane_end) begin
            a_addr = {r_x[0], YW'(1)};
            b_addr = {~r_x[0], YW'(0)};
        end else if (enter_last) begin
            a_addr = {r_x[0], YW'(0)};
            b_addr = {r_x[0], r_y + YW'(1)};
        end else begin
            a_addr = {~r_x[0], r_y + YW'(2)};
            b_addr = {r_x[0], r_y + YW'(1)};
        end
    end

    // row under construction with the current bit in place
    always_comb begin
        w_final       = r_w;
        w_final[r_z]  = cur;
    end

    assign row_we = i_accept && z_last;

    vbfe_ram #(
        .WIDTH (RW),
        .DEPTH (vbfe_pkg::ROWS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (row_we),
        .i_waddr   (w_addr),
        .i_wdata   (w_final),
        .i_re      (row_we),
        .i_raddr_a (a_addr),
        .i_raddr_b (b_addr),
        .o_rdata_a (ram_a),
        .o_rdata_b (ram_b)
    );

    // rows fetched at the last row change take over from the registers
    always_comb begin
        a_data = r_a_byp ? r_wdone : ram_a;
        eff_p  = (r_ld && !r_ld_nc) ? a_data : r_p;
        eff_nc = (r_ld && r_ld_nc) ? a_data : r_nc;
        eff_o  = r_ld ? ram_b : r_o;
    end

    // exposed sides of the voxel one plane behind
    always_comb begin
        mask = '0;
        mask[vbfe_pkg::SIDE_POS_X] = !cur;
        mask[vbfe_pkg::SIDE_NEG_X] = (r_x == XW'(1)) || !eff_o[r_z];
        mask[vbfe_pkg::SIDE_POS_Z] = z_last || !r_c[r_z + ZW'(1)];
        mask[vbfe_pkg::SIDE_NEG_Z] = (r_z == '0) || !r_c[r_z - ZW'(1)];
        mask[vbfe_pkg::SIDE_POS_Y] = y_last || !eff_p[r_z];
        mask[vbfe_pkg::SIDE_NEG_Y] = (r_y == '0) || !r_m[r_z];
    end

    assign o_rec_push  = i_accept && (r_x != '0) && r_c[r_z] && (mask != '0);
    assign o_rec.fresh = r_fresh;
    assign o_rec.mask  = mask;
    assign o_rec.pos_x = PXW'(r_x - XW'(1));
    assign o_rec.pos_y = PYW'(r_y);
    assign o_rec.pos_z = PZW'(r_z);

    // sizes, position and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gx    <= GXW'(1);
            r_gy    <= GYW'(1);
            r_gz    <= GZW'(1);
            r_x     <= '0;
            r_y     <= '0;
            r_z     <= '0;
            r_fresh <= 1'b1;
            r_ld    <= 1'b0;
        end else begin
            r_ld <= row_we;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    vbfe_pkg::CFG_GRID_X: begin
                        r_gx    <= i_cfg_data[GXW-1:0];
                        r_x     <= '0;
                        r_y     <= '0;
                        r_z     <= '0;
                        r_fresh <= 1'b1;
                    end
                    vbfe_pkg::CFG_GRID_Y: begin
                        r_gy    <= i_cfg_data[GYW-1:0];
                        r_x     <= '0;
                        r_y     <= '0;
                        r_z     <= '0;
                        r_fresh <= 1'b1;
                    end
                    vbfe_pkg::CFG_GRID_Z: begin
                        r_gz    <= i_cfg_data[GZW-1:0];
                        r_x     <= '0;
                        r_y     <= '0;
                        r_z     <= '0;
                        r_fresh <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end else if (i_accept) begin
                r_x <= n_x;
                r_y <= n_y;
                r_z <= n_z;
                if (wrap) begin
                    r_fresh <= 1'b1;
                end else if (o_rec_push) begin
                    r_fresh <= 1'b0;
                end
            end
        end
    end

    // row registers
    always_ff @(posedge i_clk) begin
        r_p  <= eff_p;
        r_o  <= eff_o;
        r_nc <= eff_nc;
        if (i_accept) begin
            r_w <= w_final;
        end
        if (row_we) begin
            r_wdone <= w_final;
            r_m     <= r_c;
            r_c     <= plane_end ? ((ny == NYW'(1)) ? w_final : eff_nc) : eff_p;
            r_ld_nc <= enter_last;
            r_a_byp <= (a_addr == w_addr);
        end
    end

endmodule

FILE: hdl/vbfe_queue.sv
module vbfe_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  vbfe_pkg::t_voxel_rec  i_rec,
    input  logic                  i_pop,
    output vbfe_pkg::t_voxel_rec  o_rec,
    output vbfe_pkg::t_queue_stat o_stat
);

    localparam int DEPTH = vbfe_pkg::QUEUE_DEPTH;
    localparam int AW    = vbfe_pkg::QUEUE_AW;
    localparam int CW    = vbfe_pkg::QUEUE_CW;

    vbfe_pkg::t_voxel_rec r_slot [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_level;
    logic          do_push, do_pop;

    assign do_push = i_push && (r_level != CW'(DEPTH));
    assign do_pop  = i_pop && (r_level != '0);

    assign o_rec        = r_slot[r_rd];
    assign o_stat.full  = (r_level == CW'(DEPTH));
    assign o_stat.empty = (r_level == '0);
    assign o_stat.level = r_level;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            r_level <= r_level + CW'(do_push) - CW'(do_pop);
        end
    end

    // record storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_rec;
        end
    end

endmodule

FILE: hdl/vbfe_back.sv
module vbfe_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  vbfe_pkg::t_voxel_rec i_rec,
    input  logic                 i_rec_valid,
    output logic                 o_rec_pop,
    input  logic                 i_out_taken,
    output logic                 o_out_valid,
    output vbfe_pkg::t_out_item  o_out
);

    localparam int NS = vbfe_pkg::NUM_SIDES;
    localparam int VW = vbfe_pkg::VERT_W;
    localparam int SW = vbfe_pkg::SIDE_W;

    logic                 r_active;
    logic [NS-1:0]        r_mask;
    vbfe_pkg::t_voxel_rec r_rec;
    logic [VW-1:0]        r_vc;
    logic                 r_out_valid;
    vbfe_pkg::t_out_item  r_out;

    logic [SW-1:0] idx;
    logic [NS-1:0] rest;
    logic          last, out_free, emit, load;

    // lowest pending side goes first
    always_comb begin
        idx = '0;
        for (int i = NS - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                idx = SW'(i);
            end
        end
        rest = r_mask & ~(NS'(1) << idx);
        last = (rest == '0);
    end

    assign out_free  = !r_out_valid || i_out_taken;
    assign emit      = r_active && out_free;
    assign load      = i_rec_valid && (!r_active || (emit && last));
    assign o_rec_pop = load;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // voxel in progress, vertex count and output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
            r_vc        <= '0;
        end else begin
            if (load) begin
                r_active <= 1'b1;
            end else if (emit && last) begin
                r_active <= 1'b0;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_taken) begin
                r_out_valid <= 1'b0;
            end
            if (load && i_rec.fresh) begin
                r_vc <= '0;
            end else if (emit) begin
                r_vc <= r_vc + VW'(4);
            end
        end
    end

    // face payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rec  <= i_rec;
            r_mask <= i_rec.mask;
        end else if (emit) begin
            r_mask <= rest;
        end
        if (emit) begin
            r_out.pos_x        <= r_rec.pos_x;
            r_out.pos_y        <= r_rec.pos_y;
            r_out.pos_z        <= r_rec.pos_z;
            r_out.side         <= vbfe_pkg::t_side'(idx);
            r_out.first_vertex <= r_vc;
            r_out.last_face    <= last;
        end
    end

endmodule

FILE: hdl/voxel_boundary_face_extract_unit.sv
// Boundary face extractor for a streamed voxel grid.
// Input queue port: push/full with i_in_item (kind, voxel_value). Send the
// grid in raster order (z fastest, then y, then x), then one plane of
// ny*nz drain items; the position returns to the origin after the drain.
// Output queue port: empty/pop with o_out_item, one face per item, sides
// in the order +x, -x, +z, -z, +y, -y, last_face set on a voxel's final face.
// Configuration port: i_cfg_valid/o_cfg_ready (always ready), index 0..2
// selects grid size x, y, z; such writes restart the stream and vertex count.
// Write sizes only while idle.
// Throughput: one input item per cycle while full is low; faces leave at one
// per cycle while the receiver pops. The face emitter is the bottleneck: it
// emits a voxel's exposed sides one at a time, and an 8-entry voxel queue
// absorbs bursts. full rises when that queue is full.
// The first face of a voxel comes once the item one plane later is accepted,
// through the queue write, the emitter load and the output register.
// Reset: sizes become 1, position and vertex count 0, queues empty. When the
// receiver stalls, the face waits in the output register, the emitter and
// queue fill, and full then holds off new items.
module voxel_boundary_face_extract_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  vbfe_pkg::t_in_item              i_in_item,
    output logic                            empty,
    input  logic                            pop,
    output vbfe_pkg::t_out_item             o_out_item,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [vbfe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [vbfe_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic                  accept;
    logic                  rec_push;
    vbfe_pkg::t_voxel_rec  rec_in;
    vbfe_pkg::t_voxel_rec  rec_head;
    vbfe_pkg::t_queue_stat q_stat;
    logic                  rec_pop;
    logic                  out_valid;
    logic                  out_taken;

    assign o_cfg_ready = 1'b1;
    assign full        = q_stat.full;
    assign accept      = push && !q_stat.full;
    assign empty       = !out_valid;
    assign out_taken   = pop && out_valid;

    // classifier with occupancy rows
    vbfe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_item      (i_in_item),
        .o_rec_push  (rec_push),
        .o_rec       (rec_in)
    );

    // voxel record queue
    vbfe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rec_push),
        .i_rec   (rec_in),
        .i_pop   (rec_pop),
        .o_rec   (rec_head),
        .o_stat  (q_stat)
    );

    // face emitter
    vbfe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec       (rec_head),
        .i_rec_valid (!q_stat.empty),
        .o_rec_pop   (rec_pop),
        .i_out_taken (out_taken),
        .o_out_valid (out_valid),
        .o_out       (o_out_item)
    );

    // faces carry a valid side code and a quad-aligned vertex number
    a_face_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ((o_out_item.side <= vbfe_pkg::SIDE_NEG_Y)
                    && (o_out_item.first_vertex[1:0] == 2'b00)))
        else $error("bad face fields");

    // only voxels with at least one exposed side enter the queue
    a_rec_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rec_push |-> (rec_in.mask != '0))
        else $error("voxel queued without faces");

    // queue level moves by at most one per cycle and stays in range
    a_queue_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ##1 (q_stat.level <= vbfe_pkg::QUEUE_CW'(vbfe_pkg::QUEUE_DEPTH))
        && ((q_stat.level == $past(q_stat.level))
            || (q_stat.level == $past(q_stat.level) + 1'b1)
            || (q_stat.level == $past(q_stat.level) - 1'b1)))
        else $error("voxel queue level jump");

endmodule
